// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the CRC engine RTL.
// Included by modules that check their own logic; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PCE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define PCE_NEVER(label, clk, rst_n, cond, msg) \
  `PCE_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ===== hdl/pce_pkg.sv =====
// Types and constants for the programmable CRC engine.
// Used by the front, back and top-level modules; depends on nothing.
`default_nettype none

package pce_pkg;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_FEED8   = 2'd1,
    OP_FEED16  = 2'd2,
    OP_FEED32  = 2'd3
  } opcode_t;

  localparam logic [2:0] CFG_POLY           = 3'd0;
  localparam logic [2:0] CFG_SEED           = 3'd1;
  localparam logic [2:0] CFG_REFLECT_IN     = 3'd2;
  localparam logic [2:0] CFG_REFLECT_OUT    = 3'd3;
  localparam logic [2:0] CFG_COMPLEMENT_OUT = 3'd4;
  localparam logic [2:0] CFG_WIDTH_32       = 3'd5;

  localparam logic [31:0] POLY_RESET = 32'h0000_1021;
  localparam logic [31:0] SEED_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] poly;
    logic [31:0] seed;
    logic        reflect_in;
    logic        reflect_out;
    logic        complement_out;
    logic        width_32;
  } cfg_t;

  // One classified word: data is left-justified, last_beat is the byte count minus one.
  typedef struct packed {
    logic        restart;
    logic [1:0]  last_beat;
    logic [31:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/pce_fifo.sv =====
// Small register-based queue used between the engine stages and on the result side.
// Depends on assert_macros.svh only.
`default_nettype none
`include "assert_macros.svh"

module pce_fifo #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] rdata_o,
  output      logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == CntW'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign rdata_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  `PCE_NEVER(a_no_push_full, clk, rst_n, push_i && full_o, "push into full queue")
  `PCE_NEVER(a_no_pop_empty, clk, rst_n, pop_i && empty_o, "pop from empty queue")
  `PCE_NEVER(a_cnt_range, clk, rst_n, cnt_r > CntW'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ===== hdl/pce_front.sv =====
// Front end of the CRC engine: accepts input words and classifies them into commands.
// Depends on pce_pkg for the opcode, configuration and command types.
`default_nettype none

module pce_front
  import pce_pkg::*;
(
  input  wire logic        push_i,
  input  wire logic        full_i,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] data_i,
  input  wire cfg_t        cfg_i,
  output      logic        cmd_push_o,
  output      cmd_t        cmd_o
);

  logic [7:0]  byte_rev;
  logic [15:0] half_rev;
  logic [31:0] word_rev;
  opcode_t     op;

  assign op         = opcode_t'(opcode_i);
  assign cmd_push_o = push_i && !full_i;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_rev[i] = data_i[7 - i];
    end
    for (int i = 0; i < 16; i++) begin
      half_rev[i] = data_i[15 - i];
    end
    for (int i = 0; i < 32; i++) begin
      word_rev[i] = data_i[31 - i];
    end
  end

  // Left-justify the data so the back end always folds from bit 31 down.
  always_comb begin
    cmd_o = '0;
    case (op)
      OP_RESTART: begin
        cmd_o.restart = 1'b1;
      end
      OP_FEED8: begin
        cmd_o.last_beat = 2'd0;
        cmd_o.data      = {(cfg_i.reflect_in ? byte_rev : data_i[7:0]), 24'h0};
      end
      OP_FEED16: begin
        cmd_o.last_beat = 2'd1;
        cmd_o.data      = {(cfg_i.reflect_in ? half_rev : data_i[15:0]), 16'h0};
      end
      OP_FEED32: begin
        cmd_o.last_beat = 2'd3;
        cmd_o.data      = cfg_i.reflect_in ? word_rev : data_i;
      end
      default: begin
        cmd_o.restart = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pce_back.sv =====
// Back end of the CRC engine: folds queued commands into the CRC register one byte per cycle
// (a last byte waits on a full result queue) and pushes the read view. Depends on pce_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pce_back
  import pce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg_i,
  input  wire logic        cmd_empty_i,
  input  wire cmd_t        cmd_i,
  output      logic        cmd_pop_o,
  input  wire logic        res_full_i,
  output      logic        res_push_o,
  output      logic [31:0] res_data_o
);

  logic        act_r, act_nxt;
  cmd_t        cur_r, cur_nxt;
  logic [31:0] crc_r, crc_nxt;

  cmd_t        cur;
  logic        take_head;
  logic        valid;
  logic        done;
  logic        go;
  logic [31:0] mask;
  logic [31:0] crc_calc;

  function automatic logic [31:0] fold8(input logic [31:0] c_in, input logic [7:0] d,
                                        input logic [31:0] p_in, input logic w32);
    logic [31:0] m;
    logic [31:0] c;
    logic [31:0] p;
    logic        fb;
    m = w32 ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    c = c_in & m;
    p = p_in & m;
    for (int i = 7; i >= 0; i--) begin
      fb = (w32 ? c[31] : c[15]) ^ d[i];
      c  = (c << 1) & m;
      if (fb) begin
        c = c ^ p;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] read_view(input logic [31:0] c_in, input cfg_t cfg);
    logic [31:0] m;
    logic [31:0] v;
    logic [31:0] r;
    m = cfg.width_32 ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    v = c_in & m;
    r = '0;
    if (cfg.width_32) begin
      for (int i = 0; i < 32; i++) begin
        r[i] = v[31 - i];
      end
    end else begin
      for (int i = 0; i < 16; i++) begin
        r[i] = v[15 - i];
      end
    end
    if (cfg.reflect_out) begin
      v = r;
    end
    if (cfg.complement_out) begin
      v = ~v & m;
    end
    return v;
  endfunction

  assign take_head = !act_r && !cmd_empty_i;
  assign cur       = act_r ? cur_r : cmd_i;
  assign valid     = act_r || !cmd_empty_i;
  assign done      = cur.restart || (cur.last_beat == 2'd0);
  assign mask      = cfg_i.width_32 ? 32'hFFFF_FFFF : 32'h0000_FFFF;
  assign crc_calc  = cur.restart ? (cfg_i.seed & mask)
                                 : fold8(crc_r, cur.data[31:24], cfg_i.poly, cfg_i.width_32);
  // Hold a restart or the last byte of a word while the result queue is full.
  assign go         = valid && !(done && res_full_i);
  assign cmd_pop_o  = take_head && go;
  assign res_push_o = go && done;
  assign res_data_o = read_view(crc_calc, cfg_i);

  always_comb begin
    act_nxt = act_r;
    cur_nxt = cur_r;
    crc_nxt = crc_r;
    if (go) begin
      crc_nxt = crc_calc;
      if (done) begin
        act_nxt = 1'b0;
      end else begin
        act_nxt           = 1'b1;
        cur_nxt.restart   = 1'b0;
        cur_nxt.last_beat = cur.last_beat - 2'd1;
        cur_nxt.data      = {cur.data[23:0], 8'h0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      crc_r <= '0;
    end else begin
      act_r <= act_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  `PCE_ASSERT(a_act_no_restart, clk, rst_n, act_r |-> !cur_r.restart,
              "restart held in multi-byte stage")
  `PCE_ASSERT(a_split_holds, clk, rst_n, (take_head && go && !done) |=> act_r,
              "multi-byte word not held after first byte")

endmodule

`default_nettype wire

// ===== hdl/programmable_crc_engine_unit.sv =====
// Top level of the programmable CRC engine: configuration registers, front end,
// command queue, back end and result queue. Depends on pce_pkg, pce_front, pce_fifo, pce_back.
//
// Usage:
//   Input side looks like a queue: drive in_opcode/in_data_in and raise push; the word is
//   taken at a clock edge where push is high and full is low. Opcodes: restart with seed,
//   feed byte (bits 7..0), feed halfword (bits 15..0), feed word (all 32 bits).
//   Result side looks like a queue too: while empty is low, out_crc_out holds the oldest
//   CRC read view; raise pop to take it. Every input word yields exactly one result word.
//   Configuration: cfg_we with cfg_index/cfg_wdata writes one register per cycle; write
//   only while the engine is idle (no word in flight).
//   A taken word goes into the command queue; the back end takes it from the queue head,
//   folds any further bytes from its own register and pushes the result into the result queue.
//   Throughput: the back end folds one byte per cycle through an 8-step XOR network, except
//   that a finished result waits while the result queue is full. The front keeps taking words
//   into the command queue meanwhile, until it fills.
//   Reset (rst_n low, synchronous) empties both queues, clears the CRC to zero and loads
//   the register defaults: polynomial 0x1021, seed all ones, 16-bit mode, no reflection.
//   When the receiver stalls, results collect in the result queue, then the back end
//   holds, then the command queue fills and full rises.
`default_nettype none

module programmable_crc_engine_unit
  import pce_pkg::*;
#(
  parameter int CMD_DEPTH = 4,
  parameter int RES_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_data_in,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [31:0] out_crc_out,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  cfg_t        cfg_r, cfg_nxt;
  logic        cmd_push;
  cmd_t        cmd_in;
  cmd_t        cmd_head;
  logic        cmd_empty;
  logic        cmd_pop;
  logic        res_full;
  logic        res_push;
  logic [31:0] res_data;
  logic        res_pop;

  // Register file: drop writes to unknown indexes, cut flags to one bit.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_POLY:           cfg_nxt.poly           = cfg_wdata;
        CFG_SEED:           cfg_nxt.seed           = cfg_wdata;
        CFG_REFLECT_IN:     cfg_nxt.reflect_in     = cfg_wdata[0];
        CFG_REFLECT_OUT:    cfg_nxt.reflect_out    = cfg_wdata[0];
        CFG_COMPLEMENT_OUT: cfg_nxt.complement_out = cfg_wdata[0];
        CFG_WIDTH_32:       cfg_nxt.width_32       = cfg_wdata[0];
        default:            cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly           <= POLY_RESET;
      cfg_r.seed           <= SEED_RESET;
      cfg_r.reflect_in     <= 1'b0;
      cfg_r.reflect_out    <= 1'b0;
      cfg_r.complement_out <= 1'b0;
      cfg_r.width_32       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify incoming words.
  pce_front u_front (
    .push_i     (push),
    .full_i     (full),
    .opcode_i   (in_opcode),
    .data_i     (in_data_in),
    .cfg_i      (cfg_r),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Decouple front and back so each can stall on its own.
  pce_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  // Fold commands into the CRC register.
  pce_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_data_o  (res_data)
  );

  assign res_pop = pop && !empty;

  // Hold finished results until the receiver takes them.
  pce_fifo #(
    .WIDTH (32),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_push),
    .wdata_i (res_data),
    .full_o  (res_full),
    .pop_i   (res_pop),
    .rdata_o (out_crc_out),
    .empty_o (empty)
  );

endmodule

`default_nettype wire
